// File: hw/rtl/mitd_pkg.sv
// Shared types and constants for the multi-input time debouncer.
// No dependencies; imported by every module of the block.
package mitd_pkg;

  localparam int PIN_W     = 8;
  localparam int TIME_W    = 32;
  localparam int DEB_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [PIN_W-1:0] POLARITY_RST = 8'd0;
  localparam logic [DEB_W-1:0] SHORT_RST    = 16'd20;
  localparam logic [DEB_W-1:0] LONG_RST     = 16'd50;
  localparam logic [PIN_W-1:0] SELECT_RST   = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLARITY = 2'd0,
    CFG_SHORT    = 2'd1,
    CFG_LONG     = 2'd2,
    CFG_SELECT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIN_W-1:0]  pin_levels;
    logic [TIME_W-1:0] now_ms;
    logic              seed_state;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] stable_levels;
    logic [PIN_W-1:0] normalized_levels;
  } out_item_t;

endpackage

// File: hw/rtl/mitd_lane.sv
// One debounce lane: last level, stable level and change time of one input.
// Depends on mitd_pkg.
module mitd_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic                       lvl,
  input  logic                       seed,
  input  logic [mitd_pkg::TIME_W-1:0] now_ms,
  input  logic                       use_long,
  input  logic [mitd_pkg::DEB_W-1:0]  short_ms,
  input  logic [mitd_pkg::DEB_W-1:0]  long_ms,
  output logic                       stable_next
);
  import mitd_pkg::*;

  logic              last_level;
  logic              stable_level;
  logic [TIME_W-1:0] change_time;
  logic              last_next;
  logic [TIME_W-1:0] change_time_next;
  logic [TIME_W-1:0] elapsed;
  logic [DEB_W-1:0]  wait_ms;

  assign wait_ms = use_long ? long_ms : short_ms;
  assign elapsed = now_ms - change_time;

  always_comb begin
    last_next        = last_level;
    stable_next      = stable_level;
    change_time_next = change_time;
    if (seed) begin
      last_next        = lvl;
      stable_next      = lvl;
      change_time_next = now_ms;
    end else if (lvl != last_level) begin
      // record the edge; stable level waits for a later sample
      last_next        = lvl;
      change_time_next = now_ms;
    end else if (lvl != stable_level) begin
      if (elapsed >= {{(TIME_W-DEB_W){1'b0}}, wait_ms}) begin
        stable_next = lvl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      stable_level <= 1'b0;
      change_time  <= '0;
    end else if (take) begin
      last_level   <= last_next;
      stable_level <= stable_next;
      change_time  <= change_time_next;
    end
  end

`ifndef SYNTHESIS
  a_seed_aligns: assert property (@(posedge clk) disable iff (rst)
    take && seed |=> (stable_level == last_level) && (change_time == $past(now_ms)))
    else $error("seeded lane not aligned");
  a_edge_keeps_stable: assert property (@(posedge clk) disable iff (rst)
    take && !seed && (lvl != last_level) |=> $stable(stable_level))
    else $error("stable level moved on a level change");
  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(last_level) && $stable(stable_level) && $stable(change_time))
    else $error("lane state moved without a transfer");
`endif

endmodule

// File: hw/rtl/mitd_merge.sv
// Merge stage: packs lane results into the two 8-bit result fields and holds them in
// the output register. Depends on mitd_pkg.
module mitd_merge #(
  parameter int LANES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LANES-1:0]      lane_stable,
  input  logic [LANES-1:0]      lane_norm,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mitd_pkg::out_item_t   out_data
);
  import mitd_pkg::*;

  logic [PIN_W-1:0] stable_vec;
  logic [PIN_W-1:0] norm_vec;
  logic             take;

  // drop lanes past the output width, pad missing ones with zero
  for (genvar b = 0; b < PIN_W; b++) begin : g_pack
    if (b < LANES) begin : g_lane
      assign stable_vec[b] = lane_stable[b];
      assign norm_vec[b]   = lane_norm[b];
    end else begin : g_pad
      assign stable_vec[b] = 1'b0;
      assign norm_vec[b]   = 1'b0;
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.stable_levels     <= stable_vec;
      out_data.normalized_levels <= norm_vec;
    end
  end

`ifndef SYNTHESIS
  a_take_loads: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("accepted sample produced no result");
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("empty output register refused a transfer");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !take |=> !out_valid)
    else $error("result repeated after transfer");
`endif

endmodule

// File: hw/rtl/multi_input_time_debouncer_top.sv
// Top level of the multi-input time debouncer: config registers, polarity
// correction, CHANNELS debounce lanes and the merge stage.
// Depends on mitd_pkg, mitd_lane, mitd_merge.
//
//   channel | direction | handshake           | payload
//   in      | sink      | in_valid/in_ready   | in_data   (pins, tick, seed)
//   out     | source    | out_valid/out_ready | out_data  (stable, normalized)
//   cfg     | sink      | cfg_we              | cfg_index, cfg_data
//
// One sample per clock while the output register can take it; each result appears in the cycle after its transfer,
// from the single output register behind the lanes.
// All lanes update in parallel in the transfer cycle; the 32-bit elapsed
// subtract and compare per lane sets the path length.
// While a result is held and out_ready is low, the output register holds and in_ready drops.
// Reset clears lane state and loads the register defaults; there is no
// clearing pass.
module multi_input_time_debouncer_top #(
  parameter int CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mitd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mitd_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [mitd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mitd_pkg::CFG_W-1:0]     cfg_data
);
  import mitd_pkg::*;

  logic [PIN_W-1:0]    polarity_mask;
  logic [DEB_W-1:0]    short_debounce_ms;
  logic [DEB_W-1:0]    long_debounce_ms;
  logic [PIN_W-1:0]    long_select_mask;
  logic [CHANNELS-1:0] lane_norm;
  logic [CHANNELS-1:0] lane_sel;
  logic [CHANNELS-1:0] lane_stable;
  logic                take;

  always_ff @(posedge clk) begin
    if (rst) begin
      polarity_mask     <= POLARITY_RST;
      short_debounce_ms <= SHORT_RST;
      long_debounce_ms  <= LONG_RST;
      long_select_mask  <= SELECT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLARITY: polarity_mask     <= cfg_data[PIN_W-1:0];
        CFG_SHORT:    short_debounce_ms <= cfg_data[DEB_W-1:0];
        CFG_LONG:     long_debounce_ms  <= cfg_data[DEB_W-1:0];
        CFG_SELECT:   long_select_mask  <= cfg_data[PIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign take = in_valid && in_ready;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    // lanes past the pin count see pin low, inverted polarity, short time
    if (g < PIN_W) begin : g_pin
      assign lane_norm[g] = in_data.pin_levels[g] ^ ~polarity_mask[g];
      assign lane_sel[g]  = long_select_mask[g];
    end else begin : g_spare
      assign lane_norm[g] = 1'b1;
      assign lane_sel[g]  = 1'b0;
    end

    mitd_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .take        (take),
      .lvl         (lane_norm[g]),
      .seed        (in_data.seed_state),
      .now_ms      (in_data.now_ms),
      .use_long    (lane_sel[g]),
      .short_ms    (short_debounce_ms),
      .long_ms     (long_debounce_ms),
      .stable_next (lane_stable[g])
    );
  end

  mitd_merge #(
    .LANES (CHANNELS)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .lane_stable (lane_stable),
    .lane_norm   (lane_norm),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
